@@ design/qsb_pkg.sv @@
// ----------------------------------------------------------------------------
// qsb_pkg: shared definitions of the quicksort buffer
// Defaults, microcode step labels, control word and status types, and the
// microprogram table itself.
// ----------------------------------------------------------------------------
package qsb_pkg;

  localparam int QSB_MAX_ELEMS  = 64;
  localparam int QSB_DATA_WIDTH = 32;

  // Microprogram addresses. The sequencer falls through to the next label,
  // so the order of the members is the layout of the program.
  typedef enum logic [4:0] {
    S_LOAD,     // take input transfers until one is marked last
    S_START,    // clear the range stack, skip the sort for fewer than two
    S_PUSH0,    // push the whole set
    S_POP,      // pop a range, or leave for output when the stack is empty
    S_POPD,     // latch low and high of the popped range, pop again if it is bad
    S_PINIT,    // i = low, j = high, fetch the pivot
    S_PPIV,     // latch the pivot
    S_PLOOP,    // partition loop head
    S_RREAD,    // right-to-left scan: fetch element j
    S_RTEST,    // element j above pivot: keep scanning
    S_RSWAP,    // element j moves into the pivot slot at i
    S_RSWAP2,   // pivot moves to j
    S_LREAD,    // left-to-right scan: fetch element i
    S_LTEST,    // element i below pivot: keep scanning
    S_LSWAP,    // element i moves into the pivot slot at j
    S_LSWAP2,   // pivot moves to i
    S_RDEC,
    S_LINC,
    S_PEND,     // partition done, pivot at i
    S_PPUSHL,
    S_PRIGHT,
    S_PPUSHR,
    S_OINIT,    // output phase
    S_OREAD,
    S_ODATA,
    S_OHOLD,
    S_OCHK,
    S_FIN
  } step_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_WAIT_LAST,
    C_LT2,
    C_SP_ZERO,
    C_BAD_RANGE,
    C_I_GE_J,
    C_RD_GT_PK,
    C_RD_LT_PK,
    C_NO_LEFT,
    C_NO_RIGHT,
    C_NO_OUT_XFER,
    C_K_LT_N
  } cond_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_LO,
    RD_I,
    RD_J,
    RD_K
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_IN,
    WR_I_RD,
    WR_I_PK,
    WR_J_RD,
    WR_J_PK
  } wr_sel_t;

  typedef enum logic [1:0] {
    IX_HOLD,
    IX_LOAD,
    IX_INC,
    IX_DEC
  } idx_op_t;

  typedef enum logic [2:0] {
    STK_NONE,
    STK_CLEAR,
    STK_POP,
    STK_PUSH_ALL,
    STK_PUSH_LEFT,
    STK_PUSH_RIGHT
  } stk_op_t;

  typedef enum logic [2:0] {
    M_NONE,
    M_LD_RANGE,
    M_LD_PK,
    M_K_CLR,
    M_LD_OUT,
    M_K_XFER,
    M_CNT_CLR
  } misc_op_t;

  typedef struct packed {
    cond_t    cond;
    step_t    target;
    logic     in_rdy;
    logic     out_vld;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    idx_op_t  i_op;
    idx_op_t  j_op;
    stk_op_t  stk_op;
    misc_op_t misc;
  } ctl_t;

  typedef struct packed {
    logic in_xfer_last;
    logic out_xfer;
    logic lt2;
    logic sp_zero;
    logic bad_range;
    logic i_ge_j;
    logic rd_gt_pk;
    logic rd_lt_pk;
    logic no_left;
    logic no_right;
    logic k_lt_n;
  } status_t;

  // The microprogram. Each step names its jump condition and target; when
  // the condition is false the sequencer moves to the next step.
  function automatic ctl_t qsb_ucode(step_t s);
    ctl_t c;
    c = '{cond: C_NEXT, target: S_LOAD, in_rdy: 1'b0, out_vld: 1'b0,
          rd_sel: RD_NONE, wr_sel: WR_NONE, i_op: IX_HOLD, j_op: IX_HOLD,
          stk_op: STK_NONE, misc: M_NONE};
    case (s)
      S_LOAD: begin
        c.in_rdy = 1'b1; c.wr_sel = WR_IN;
        c.cond = C_WAIT_LAST; c.target = S_LOAD;
      end
      S_START: begin
        c.stk_op = STK_CLEAR; c.cond = C_LT2; c.target = S_OINIT;
      end
      S_PUSH0:  c.stk_op = STK_PUSH_ALL;
      S_POP: begin
        c.stk_op = STK_POP; c.cond = C_SP_ZERO; c.target = S_OINIT;
      end
      S_POPD: begin
        c.misc = M_LD_RANGE; c.cond = C_BAD_RANGE; c.target = S_POP;
      end
      S_PINIT: begin
        c.i_op = IX_LOAD; c.j_op = IX_LOAD; c.rd_sel = RD_LO;
      end
      S_PPIV:   c.misc = M_LD_PK;
      S_PLOOP: begin
        c.cond = C_I_GE_J; c.target = S_PEND;
      end
      S_RREAD: begin
        c.rd_sel = RD_J; c.cond = C_I_GE_J; c.target = S_PLOOP;
      end
      S_RTEST: begin
        c.cond = C_RD_GT_PK; c.target = S_RDEC;
      end
      S_RSWAP: begin
        c.wr_sel = WR_I_RD; c.i_op = IX_INC;
      end
      S_RSWAP2: c.wr_sel = WR_J_PK;
      S_LREAD: begin
        c.rd_sel = RD_I; c.cond = C_I_GE_J; c.target = S_PLOOP;
      end
      S_LTEST: begin
        c.cond = C_RD_LT_PK; c.target = S_LINC;
      end
      S_LSWAP: begin
        c.wr_sel = WR_J_RD; c.j_op = IX_DEC;
      end
      S_LSWAP2: begin
        c.wr_sel = WR_I_PK; c.cond = C_ALWAYS; c.target = S_PLOOP;
      end
      S_RDEC: begin
        c.j_op = IX_DEC; c.cond = C_ALWAYS; c.target = S_RREAD;
      end
      S_LINC: begin
        c.i_op = IX_INC; c.cond = C_ALWAYS; c.target = S_LREAD;
      end
      S_PEND: begin
        c.cond = C_NO_LEFT; c.target = S_PRIGHT;
      end
      S_PPUSHL: c.stk_op = STK_PUSH_LEFT;
      S_PRIGHT: begin
        c.cond = C_NO_RIGHT; c.target = S_POP;
      end
      S_PPUSHR: begin
        c.stk_op = STK_PUSH_RIGHT; c.cond = C_ALWAYS; c.target = S_POP;
      end
      S_OINIT:  c.misc = M_K_CLR;
      S_OREAD:  c.rd_sel = RD_K;
      S_ODATA:  c.misc = M_LD_OUT;
      S_OHOLD: begin
        c.out_vld = 1'b1; c.misc = M_K_XFER;
        c.cond = C_NO_OUT_XFER; c.target = S_OHOLD;
      end
      S_OCHK: begin
        c.cond = C_K_LT_N; c.target = S_OREAD;
      end
      S_FIN: begin
        c.misc = M_CNT_CLR; c.cond = C_ALWAYS; c.target = S_LOAD;
      end
      default: begin
        c.cond = C_ALWAYS; c.target = S_LOAD;
      end
    endcase
    return c;
  endfunction

endpackage

@@ design/qsb_in_if.sv @@
// ----------------------------------------------------------------------------
// qsb_in_if: input channel of the quicksort buffer
// Valid/ready handshake carrying one value and its last mark.
// ----------------------------------------------------------------------------
interface qsb_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

@@ design/qsb_out_if.sv @@
// ----------------------------------------------------------------------------
// qsb_out_if: result channel of the quicksort buffer
// Valid/ready handshake carrying one sorted value and its last mark.
// ----------------------------------------------------------------------------
interface qsb_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sorted_value;
  logic                         last_res;

  modport source (output valid, output sorted_value, output last_res, input ready);
  modport sink   (input valid, input sorted_value, input last_res, output ready);
endinterface

@@ design/quicksort_buffer.sv @@
// ----------------------------------------------------------------------------
// quicksort_buffer: load, sort and replay a set of signed values
// Top level: microcode sequencer driving the element store datapath.
// ----------------------------------------------------------------------------
// Values arrive one per transfer on in_ch and are stored in order; up to
// MAX_ELEMS are kept and further values of the same set are dropped. The
// transfer marked last closes the set: the block stops accepting input,
// sorts the stored values ascending with an in-place quicksort (first
// element of each range as pivot, ranges kept on an internal stack) and
// then sends every stored value on out_ch in sorted order, the final one
// with last_res set. Loading can accept one transfer per cycle. Sorting
// goes through the element store, at most one access per microcode step:
// a scanned element is fetched, compared with the pivot and passed, and a
// swap writes the element into the pivot slot, then the pivot into its
// old place. Each result is read, latched into the output register and
// held on out_ch until out_ch.ready takes it. The next set may be loaded
// once the final result has been transferred.
// ----------------------------------------------------------------------------
module quicksort_buffer #(
  parameter int MAX_ELEMS  = qsb_pkg::QSB_MAX_ELEMS,
  parameter int DATA_WIDTH = qsb_pkg::QSB_DATA_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  qsb_in_if.sink    in_ch,
  qsb_out_if.source out_ch
);
  import qsb_pkg::*;

  // Control word of the current step, and the flags it branches on.
  ctl_t    ctl;
  status_t st;

  // The sequencer holds the step counter and the microprogram table.
  qsb_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .ctl   (ctl)
  );

  // The datapath owns both memories, the partition indices and the pivot,
  // and it drives both handshakes from the control word.
  qsb_datapath #(
    .MAX_ELEMS  (MAX_ELEMS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .st     (st),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

@@ design/qsb_sequencer.sv @@
// ----------------------------------------------------------------------------
// qsb_sequencer: microprogram counter of the quicksort buffer
// Looks up the control word of the current step and branches on status.
// ----------------------------------------------------------------------------
module qsb_sequencer (
  input  logic             clk,
  input  logic             rst_n,
  input  qsb_pkg::status_t st,
  output qsb_pkg::ctl_t    ctl
);
  import qsb_pkg::*;

  step_t upc_r, upc_nxt;
  logic  take;

  always_comb begin
    ctl = qsb_ucode(upc_r);
    case (ctl.cond)
      C_NEXT:        take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_WAIT_LAST:   take = !st.in_xfer_last;
      C_LT2:         take = st.lt2;
      C_SP_ZERO:     take = st.sp_zero;
      C_BAD_RANGE:   take = st.bad_range;
      C_I_GE_J:      take = st.i_ge_j;
      C_RD_GT_PK:    take = st.rd_gt_pk;
      C_RD_LT_PK:    take = st.rd_lt_pk;
      C_NO_LEFT:     take = st.no_left;
      C_NO_RIGHT:    take = st.no_right;
      C_NO_OUT_XFER: take = !st.out_xfer;
      C_K_LT_N:      take = st.k_lt_n;
      default:       take = 1'b1;
    endcase
    upc_nxt = take ? ctl.target : step_t'(upc_r + 5'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_LOAD;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

@@ design/qsb_datapath.sv @@
// ----------------------------------------------------------------------------
// qsb_datapath: element store, range stack and index registers
// Executes the control word of each step and reports branch status.
// ----------------------------------------------------------------------------
module qsb_datapath #(
  parameter int MAX_ELEMS  = qsb_pkg::QSB_MAX_ELEMS,
  parameter int DATA_WIDTH = qsb_pkg::QSB_DATA_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  qsb_pkg::ctl_t    ctl,
  output qsb_pkg::status_t st,
  qsb_in_if.sink           in_ch,
  qsb_out_if.source        out_ch
);
  import qsb_pkg::*;

  localparam int IW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int CW = $clog2(MAX_ELEMS + 1);

  logic signed [DATA_WIDTH-1:0] mem [MAX_ELEMS];
  logic [2*IW-1:0]              stk [MAX_ELEMS];

  logic signed [DATA_WIDTH-1:0] rd_r, pk_r, out_val_r;
  logic                         out_last_r;
  logic [2*IW-1:0]              srd_r;
  logic [IW-1:0]                i_r, j_r, lo_r, hi_r;
  logic [CW-1:0]                cnt_r, sp_r, k_r;

  logic                         in_xfer, out_xfer;
  logic                         mem_we, stk_we;
  logic [IW-1:0]                mem_wa, mem_ra;
  logic signed [DATA_WIDTH-1:0] mem_wd;
  logic [IW-1:0]                stk_wa;
  logic [2*IW-1:0]              stk_wd;
  logic                         sp_nonzero;
  logic [IW-1:0]                srd_lo, srd_hi;

  assign in_ch.ready         = ctl.in_rdy;
  assign out_ch.valid        = ctl.out_vld;
  assign out_ch.sorted_value = out_val_r;
  assign out_ch.last_res     = out_last_r;
  assign in_xfer             = in_ch.valid && ctl.in_rdy;
  assign out_xfer            = out_ch.ready && ctl.out_vld;
  assign sp_nonzero          = (sp_r != '0);
  assign srd_lo              = srd_r[2*IW-1:IW];
  assign srd_hi              = srd_r[IW-1:0];

  // Element store write and read address selection.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = i_r;
    mem_wd = rd_r;
    case (ctl.wr_sel)
      WR_IN: begin
        mem_we = in_xfer && (cnt_r < CW'(MAX_ELEMS));
        mem_wa = cnt_r[IW-1:0];
        mem_wd = in_ch.value;
      end
      WR_I_RD: begin mem_we = 1'b1; mem_wa = i_r; mem_wd = rd_r; end
      WR_I_PK: begin mem_we = 1'b1; mem_wa = i_r; mem_wd = pk_r; end
      WR_J_RD: begin mem_we = 1'b1; mem_wa = j_r; mem_wd = rd_r; end
      WR_J_PK: begin mem_we = 1'b1; mem_wa = j_r; mem_wd = pk_r; end
      default: mem_we = 1'b0;
    endcase
    case (ctl.rd_sel)
      RD_LO:   mem_ra = lo_r;
      RD_I:    mem_ra = i_r;
      RD_J:    mem_ra = j_r;
      RD_K:    mem_ra = k_r[IW-1:0];
      default: mem_ra = i_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (ctl.rd_sel != RD_NONE) begin
      rd_r <= mem[mem_ra];
    end
  end

  // Range stack: pushes write at the stack pointer, pops read below it.
  always_comb begin
    stk_we = 1'b0;
    stk_wa = sp_r[IW-1:0];
    stk_wd = {lo_r, IW'(i_r - IW'(1))};
    case (ctl.stk_op)
      STK_PUSH_ALL: begin
        stk_we = 1'b1;
        stk_wd = {{IW{1'b0}}, IW'(cnt_r - CW'(1))};
      end
      STK_PUSH_LEFT: begin
        stk_we = 1'b1;
        stk_wd = {lo_r, IW'(i_r - IW'(1))};
      end
      STK_PUSH_RIGHT: begin
        stk_we = 1'b1;
        stk_wd = {IW'(i_r + IW'(1)), hi_r};
      end
      default: stk_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[stk_wa] <= stk_wd;
    end
    if (ctl.stk_op == STK_POP && sp_nonzero) begin
      srd_r <= stk[IW'(sp_r - CW'(1))];
    end
  end

  // Control counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sp_r  <= '0;
      k_r   <= '0;
    end else begin
      if (ctl.wr_sel == WR_IN && in_xfer && cnt_r < CW'(MAX_ELEMS)) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (ctl.misc == M_CNT_CLR) begin
        cnt_r <= '0;
      end
      case (ctl.stk_op)
        STK_CLEAR: sp_r <= '0;
        STK_POP: begin
          if (sp_nonzero) begin
            sp_r <= sp_r - CW'(1);
          end
        end
        STK_PUSH_ALL, STK_PUSH_LEFT, STK_PUSH_RIGHT: sp_r <= sp_r + CW'(1);
        default: sp_r <= sp_r;
      endcase
      if (ctl.misc == M_K_CLR) begin
        k_r <= '0;
      end else if (ctl.misc == M_K_XFER && out_xfer) begin
        k_r <= k_r + CW'(1);
      end
    end
  end

  // Partition registers and the output register.
  always_ff @(posedge clk) begin
    case (ctl.i_op)
      IX_LOAD: i_r <= lo_r;
      IX_INC:  i_r <= i_r + IW'(1);
      IX_DEC:  i_r <= i_r - IW'(1);
      default: i_r <= i_r;
    endcase
    case (ctl.j_op)
      IX_LOAD: j_r <= hi_r;
      IX_INC:  j_r <= j_r + IW'(1);
      IX_DEC:  j_r <= j_r - IW'(1);
      default: j_r <= j_r;
    endcase
    if (ctl.misc == M_LD_RANGE) begin
      lo_r <= srd_lo;
      hi_r <= srd_hi;
    end
    if (ctl.misc == M_LD_PK) begin
      pk_r <= rd_r;
    end
    if (ctl.misc == M_LD_OUT) begin
      out_val_r  <= rd_r;
      out_last_r <= ((k_r + CW'(1)) == cnt_r);
    end
  end

  always_comb begin
    st.in_xfer_last = in_xfer && in_ch.last;
    st.out_xfer     = out_xfer;
    st.lt2          = (cnt_r < CW'(2));
    st.sp_zero      = !sp_nonzero;
    st.bad_range    = (srd_lo >= srd_hi) ||
                      ((IW+1)'(srd_hi) >= (IW+1)'(MAX_ELEMS));
    st.i_ge_j       = (i_r >= j_r);
    st.rd_gt_pk     = (rd_r > pk_r);
    st.rd_lt_pk     = (rd_r < pk_r);
    st.no_left      = !((IW+1)'(i_r) > ((IW+1)'(lo_r) + (IW+1)'(1)));
    st.no_right     = !(((IW+1)'(i_r) + (IW+1)'(1)) < (IW+1)'(hi_r));
    st.k_lt_n       = (k_r < cnt_r);
  end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench of the quicksort buffer
// Loads sets of signed values into the block and checks that every set comes
// back on the result channel in ascending order, with the final value marked.
// Both sides stall at random, but for the sets run while calm is set.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW        = qsb_pkg::QSB_DATA_WIDTH;
  localparam int MAX_ELEMS = qsb_pkg::QSB_MAX_ELEMS;

  // Largest and smallest values that a field of DW bits can hold.
  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

  // The run gives up when this limit is reached without a single transfer. A set
  // of 64 values that arrives already in order is one of the slowest sorts,
  // and it stays far below this limit.
  localparam int STALL_LIMIT = 50000;

  // Cycles to wait after the last expected result, so that a stray extra
  // result is still caught.
  localparam int DRAIN_CYCLES = 20;

  localparam int DIRECTED_ROWS = 19;
  localparam int RANDOM_ITEMS  = 200;

  // Kinds of random sets: wide random values, a narrow range full of
  // duplicates, runs that are already ascending or descending, and a mix of
  // the field's extremes.
  typedef enum int {
    SHAPE_WIDE,
    SHAPE_DUPS,
    SHAPE_UP,
    SHAPE_DOWN,
    SHAPE_EDGES
  } shape_t;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 last;
  } sorted_item_t;

  // One row of the directed table. Where typed is set, the row is a set of
  // its own and exp_value is the one result that it must return.
  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 last;
    logic                 typed;
    logic signed [DW-1:0] exp_value;
  } stim_row_t;

  logic clk;
  logic rst_n;

  qsb_in_if  #(.DATA_WIDTH(DW)) in_ch ();
  qsb_out_if #(.DATA_WIDTH(DW)) out_ch ();

  quicksort_buffer #(
    .MAX_ELEMS (MAX_ELEMS),
    .DATA_WIDTH(DW)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Our own picture of the block: the values of the set being loaded and
  // the results that it still owes, oldest first.
  logic signed [DW-1:0] held_vals [MAX_ELEMS];
  logic [6:0]           held_count;
  sorted_item_t         pending_sorted [$];

  stim_row_t directed_rows [DIRECTED_ROWS];

  int  mismatches;
  // While calm is set neither side stalls.
  logic calm;

  always #1 clk = ~clk;

  // Takes one accepted value into the set. Values past the capacity are
  // dropped, just as the block drops them. A value marked last closes the
  // set: the stored values are put in ascending order and each becomes one
  // expected result, the final one marked. The set then starts over empty.
  task automatic stage_value(input logic signed [DW-1:0] v, input logic lst);
    logic signed [DW-1:0] t;
    sorted_item_t         r;
    int                   a;
    int                   b;
    if (held_count < MAX_ELEMS) begin
      held_vals[held_count] = v;
      held_count++;
    end
    if (lst) begin
      // An insertion sort is plenty at these sizes; the order of equal
      // values cannot be seen at the output.
      for (a = 1; a < held_count; a++) begin
        t = held_vals[a];
        b = a;
        while (b > 0 && held_vals[b-1] > t) begin
          held_vals[b] = held_vals[b-1];
          b--;
        end
        held_vals[b] = t;
      end
      for (a = 0; a < held_count; a++) begin
        r.value = held_vals[a];
        r.last  = (a == held_count - 1);
        pending_sorted.push_back(r);
      end
      held_count = 0;
    end
  endtask

  // Offers one value on the input channel and returns at the rising edge at
  // which the block takes it. Valid stays high from one item to the next
  // unless a random gap is drawn, so there is one assignment per edge.
  task automatic send_item(input logic signed [DW-1:0] v, input logic lst);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= lst;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic signed [DW-1:0] pick_value(input shape_t shape, input int idx,
                                                      input logic signed [DW-1:0] base);
    logic signed [DW-1:0] r;
    case (shape)
      SHAPE_DUPS: begin
        r = $urandom_range(8);
        r = r - 4;
      end
      SHAPE_UP:   r = base + idx;
      SHAPE_DOWN: r = base - idx;
      SHAPE_EDGES: begin
        case ($urandom_range(4))
          0: r = VMIN;
          1: r = VMAX;
          2: r = '0;
          3: r = '1;
          default: r = $urandom;
        endcase
      end
      default: r = $urandom;
    endcase
    return r;
  endfunction

  // Result side: ready drops with a chance of about six in a hundred, never while
  // calm is set. It changes only at the falling edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  // Every result transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    sorted_item_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_sorted.size() == 0) begin
        $display("%0t: unexpected result: expected none, got value %0d last %0b",
                 $time, out_ch.sorted_value, out_ch.last_res);
        mismatches++;
      end else begin
        e = pending_sorted.pop_front();
        if (out_ch.sorted_value !== e.value) begin
          $display("%0t: sorted_value mismatch: expected %0d, got %0d",
                   $time, e.value, out_ch.sorted_value);
          mismatches++;
        end
        if (out_ch.last_res !== e.last) begin
          $display("%0t: last_res mismatch: expected %0b, got %0b",
                   $time, e.last, out_ch.last_res);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run once STALL_LIMIT is reached with no transfer on
  // either channel; any transfer starts the wait over.
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall = 0;
      else
        stall++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results still expected",
             $time, STALL_LIMIT, pending_sorted.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int                   row;
    int                   set_no;
    int                   sent;
    int                   len;
    int                   k;
    shape_t               shape;
    logic signed [DW-1:0] base;
    logic signed [DW-1:0] v;
    sorted_item_t         r;

    clk         = 1'b0;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.last  = 1'b0;
    held_count  = '0;
    mismatches  = 0;
    calm        = 1'b0;

    // Single-value sets come back unchanged, so their result is typed in.
    // The longer sets cover duplicates, reversed and ordered input, and the
    // extremes side by side; they are checked against the predictor.
    directed_rows = '{
      '{VMAX,  1'b1, 1'b1, VMAX},
      '{VMIN,  1'b1, 1'b1, VMIN},
      '{'0,    1'b1, 1'b1, '0},
      '{'1,    1'b1, 1'b1, '1},
      '{7,     1'b0, 1'b0, '0},
      '{VMIN,  1'b0, 1'b0, '0},
      '{VMAX,  1'b0, 1'b0, '0},
      '{7,     1'b0, 1'b0, '0},
      '{'1,    1'b1, 1'b0, '0},
      '{3,     1'b0, 1'b0, '0},
      '{2,     1'b0, 1'b0, '0},
      '{1,     1'b1, 1'b0, '0},
      '{9,     1'b0, 1'b0, '0},
      '{9,     1'b0, 1'b0, '0},
      '{9,     1'b1, 1'b0, '0},
      '{VMIN,  1'b0, 1'b0, '0},
      '{'1,    1'b0, 1'b0, '0},
      '{'0,    1'b0, 1'b0, '0},
      '{VMAX,  1'b1, 1'b0, '0}
    };

    // Reset is released at a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      send_item(directed_rows[row].value, directed_rows[row].last);
      if (directed_rows[row].typed) begin
        // A typed row is a whole set, so the predictor would start and end
        // empty; the typed result stands in for its work.
        r.value = directed_rows[row].exp_value;
        r.last  = 1'b1;
        pending_sorted.push_back(r);
      end else begin
        stage_value(directed_rows[row].value, directed_rows[row].last);
      end
    end

    // Random sets, mostly short. Set 2 fills the store exactly and set 5
    // runs past it, so that the store-full case drops values and always
    // drops the marked value too while still sorting the stored set. Sets 7
    // to 11 run with no stalls on either side.
    set_no = 0;
    sent   = 0;
    while (sent < RANDOM_ITEMS) begin
      if (set_no == 2)
        len = MAX_ELEMS;
      else if (set_no == 5)
        len = MAX_ELEMS + $urandom_range(1, 4);
      else
        len = $urandom_range(1, 12);
      calm  = (set_no >= 7 && set_no < 12);
      shape = shape_t'($urandom_range(4));
      base  = $urandom;
      for (k = 0; k < len; k++) begin
        v = pick_value(shape, k, base);
        send_item(v, k == len - 1);
        stage_value(v, k == len - 1);
      end
      sent += len;
      set_no++;
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    // Wait for every owed result, then a little longer for strays. The
    // watchdog bounds this wait.
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
design/qsb_pkg.sv
design/qsb_in_if.sv
design/qsb_out_if.sv
design/qsb_sequencer.sv
design/qsb_datapath.sv
design/quicksort_buffer.sv
sim/tb.sv
